// ===== src/boct_pkg.sv =====
`default_nettype none

package boct_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int COUNT_BITS_DEF = 32;
  localparam int PC_W           = 24;
  localparam int ADDR_W         = 16;
  localparam int CNT_OUT_W      = 32;
  localparam int IDX_OUT_W      = 6;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_FULL   = 3'd2,
    ST_REPORT = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_REPORT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [PC_W-1:0]    branch_pc;
    logic [ADDR_W-1:0]  target_addr;
    logic [ADDR_W-1:0]  next_addr;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [PC_W-1:0]      entry_pc;
    logic [CNT_OUT_W-1:0] taken_count;
    logic [CNT_OUT_W-1:0] not_taken_count;
    logic                 diverges_once;
    logic                 last;
  } out_t;

endpackage

`default_nettype wire

// ===== src/branch_outcome_count_table_top.sv =====
`default_nettype none
// Record transaction: a hit in slot k ends the search at slot k; a miss scans all used entries
// and then allocates a new entry, or reports full when all ENTRIES slots are in use.
// Report transaction: the final result is given once the scan over all used entries ends;
// each found entry is sent once the next one is found, and a stall holds the scan while one waits.
// One transaction at a time: the next input is accepted in the cycle after the result is loaded.
// Synchronous active-low reset clears the entry count and control state, not the table memory.

module branch_outcome_count_table_top import boct_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int MEM_W = PC_W + 2 * COUNT_BITS;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [MEM_W-1:0] mem_rd_data;

  boct_ctrl #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  boct_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

// ===== src/boct_ram.sv =====
`default_nettype none

module boct_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 88,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/boct_ctrl.sv =====
`default_nettype none

module boct_ctrl import boct_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int USED_W = $clog2(ENTRIES + 1),
  localparam int MEM_W  = PC_W + 2 * COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_t                   out_data,
  output logic                   mem_wr_en,
  output logic [IDX_W-1:0]       mem_wr_addr,
  output logic [MEM_W-1:0]       mem_wr_data,
  output logic                   mem_rd_en,
  output logic [IDX_W-1:0]       mem_rd_addr,
  input  wire logic [MEM_W-1:0]  mem_rd_data
);

  localparam int CEXT_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam int IEXT_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t            state_r, state_nxt;
  in_t               req_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  out_t              res_r, res_nxt;
  logic              have_r, have_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic                  accept;
  logic                  out_free;
  logic [PC_W-1:0]       rd_pc;
  logic [COUNT_BITS-1:0] rd_tk;
  logic [COUNT_BITS-1:0] rd_nt;
  logic                  taken;
  logic                  hit;
  logic                  last_idx;
  logic                  full;
  logic                  used_zero;
  logic                  rd_once;
  logic                  blocked;
  logic [COUNT_BITS-1:0] base_tk;
  logic [COUNT_BITS-1:0] base_nt;
  logic [COUNT_BITS-1:0] new_tk;
  logic [COUNT_BITS-1:0] new_nt;
  logic [IDX_W-1:0]      upd_slot;
  out_t                  cur_res;
  out_t                  none_res;

  function automatic logic once_only(logic [COUNT_BITS-1:0] t, logic [COUNT_BITS-1:0] n);
    return (t == COUNT_BITS'(1)) != (n == COUNT_BITS'(1));
  endfunction

  function automatic out_t make_res(status_t st, logic [IDX_W-1:0] slot,
                                    logic [PC_W-1:0] pc, logic [COUNT_BITS-1:0] t,
                                    logic [COUNT_BITS-1:0] n, logic div, logic lst);
    out_t             r;
    logic [IEXT_W-1:0] slot_ext;
    logic [CEXT_W-1:0] t_ext;
    logic [CEXT_W-1:0] n_ext;
    slot_ext          = IEXT_W'(slot);
    t_ext             = CEXT_W'(t);
    n_ext             = CEXT_W'(n);
    r.status          = st;
    r.entry_index     = slot_ext[IDX_OUT_W-1:0];
    r.entry_pc        = pc;
    r.taken_count     = t_ext[CNT_OUT_W-1:0];
    r.not_taken_count = n_ext[CNT_OUT_W-1:0];
    r.diverges_once   = div;
    r.last            = lst;
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign rd_pc = mem_rd_data[MEM_W-1 -: PC_W];
  assign rd_tk = mem_rd_data[2*COUNT_BITS-1 -: COUNT_BITS];
  assign rd_nt = mem_rd_data[COUNT_BITS-1:0];

  assign taken     = (req_r.target_addr == req_r.next_addr);
  assign hit       = (rd_pc == req_r.branch_pc);
  assign last_idx  = (USED_W'(idx_r) + USED_W'(1)) == used_r;
  assign full      = (used_r == USED_W'(ENTRIES));
  assign used_zero = (used_r == '0);
  assign rd_once   = once_only(rd_tk, rd_nt);
  assign blocked   = rd_once && have_r && !out_free;

  assign base_tk  = (state_r == S_SEARCH) ? rd_tk : '0;
  assign base_nt  = (state_r == S_SEARCH) ? rd_nt : '0;
  assign upd_slot = (state_r == S_SEARCH) ? idx_r : used_r[IDX_W-1:0];
  assign new_tk   = (taken && base_tk != CNT_MAX) ? base_tk + COUNT_BITS'(1) : base_tk;
  assign new_nt   = (!taken && base_nt != CNT_MAX) ? base_nt + COUNT_BITS'(1) : base_nt;

  assign cur_res  = make_res(ST_REPORT, idx_r, rd_pc, rd_tk, rd_nt, 1'b1, 1'b0);
  assign none_res = make_res(ST_NONE, '0, '0, '0, '0, 1'b0, 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_REPORT) begin
            state_nxt = used_zero ? S_EMIT : S_REPORT;
          end else begin
            state_nxt = used_zero ? S_ALLOC : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt = S_EMIT;
        end else if (last_idx) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        state_nxt = S_EMIT;
      end
      S_REPORT: begin
        if (!blocked && last_idx) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = upd_slot;
    mem_wr_data   = {(state_r == S_SEARCH) ? rd_pc : req_r.branch_pc, new_tk, new_nt};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r + IDX_W'(1);
    unique case (state_r)
      S_IDLE: begin
        idx_nxt     = '0;
        have_nxt    = 1'b0;
        mem_rd_addr = '0;
        res_nxt     = none_res;
        if (accept && !used_zero) begin
          mem_rd_en = 1'b1;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          mem_wr_en = 1'b1;
          res_nxt   = make_res(ST_HIT, idx_r, rd_pc, new_tk, new_nt,
                               once_only(new_tk, new_nt), 1'b1);
        end else if (!last_idx) begin
          idx_nxt   = idx_r + IDX_W'(1);
          mem_rd_en = 1'b1;
        end
      end
      S_ALLOC: begin
        if (full) begin
          res_nxt = make_res(ST_FULL, '0, req_r.branch_pc, '0, '0, 1'b0, 1'b1);
        end else begin
          mem_wr_en = 1'b1;
          used_nxt  = used_r + USED_W'(1);
          res_nxt   = make_res(ST_NEW, upd_slot, req_r.branch_pc, new_tk, new_nt,
                               once_only(new_tk, new_nt), 1'b1);
        end
      end
      S_REPORT: begin
        if (!blocked) begin
          if (rd_once && have_r) begin
            out_nxt       = res_r;
            out_valid_nxt = 1'b1;
          end
          if (rd_once) begin
            res_nxt  = cur_res;
            have_nxt = 1'b1;
          end
          if (last_idx) begin
            if (rd_once || have_r) begin
              res_nxt.last = 1'b1;
            end else begin
              res_nxt = none_res;
            end
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            mem_rd_en = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(ENTRIES))
    else $error("allocated entry count exceeds table size");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_REPORT) |-> USED_W'(idx_r) < used_r)
    else $error("scan index beyond allocated entries");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_SEARCH || state_r == S_ALLOC))
    else $error("table written outside a record transaction");

  a_nonlast_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (state_r == S_REPORT || state_r == S_EMIT))
    else $error("non-final result outside a report transaction");
`endif

endmodule

`default_nettype wire
